// ----- rtl/oaht_pkg.sv -----
// Shared codes, widths and the write command type of the open-addressing hash table.
package oaht_pkg;

    localparam int KEY_W = 32;
    localparam int HASH_W = 32;
    localparam int VAL_W = 64;
    localparam int LIMIT_W = 8;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd192;

    localparam logic [1:0] KIND_GET = 2'd0;
    localparam logic [1:0] KIND_SET = 2'd1;
    localparam logic [1:0] KIND_DEL = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [1:0] MARK_EMPTY = 2'd0;
    localparam logic [1:0] MARK_LIVE = 2'd1;
    localparam logic [1:0] MARK_TOMB = 2'd2;

    typedef struct packed {
        logic       mark_we;
        logic       kv_we;
        logic [1:0] mark;
    } oaht_wr_t;

endpackage

// ----- rtl/open_addressing_hash_table.sv -----
// Open-addressing hash table with linear probing and tombstones (top level).
//
// Requests (kind, key_id, key_hash, new_value) enter on req_valid/req_ready;
// one result item (status, was_new, read_value) leaves on resp_valid/resp_ready
// for every request. cfg_we writes fill_limit from cfg_wdata; the user must
// write it only while the block is idle, which the block does not enforce.
// After reset a clearing pass marks all SLOTS slots empty, one slot per cycle,
// and req_ready stays low until it ends. One request is handled at a time.
// The probe reads one slot per cycle from the slot memories. An accepted request
// passes S_ADDR, then S_PROBE walks the slots to an empty slot, a hit or a full
// lap, and S_DONE loads the result. When SLOTS is not a power of two, S_MOD
// first takes the hash remainder by reciprocal multiplication. Get and delete on
// an empty table, and unused kinds, go straight to S_DONE without probing.
// A new request may be accepted while the previous result still waits; if the
// receiver stalls, the finished request holds until the output register frees.
module open_addressing_hash_table
    import oaht_pkg::*;
#(
    parameter int SLOTS = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [LIMIT_W-1:0] cfg_wdata,
    input  logic               req_valid,
    output logic               req_ready,
    input  logic [1:0]         kind,
    input  logic [KEY_W-1:0]   key_id,
    input  logic [HASH_W-1:0]  key_hash,
    input  logic [VAL_W-1:0]   new_value,
    output logic               resp_valid,
    input  logic               resp_ready,
    output logic [1:0]         status,
    output logic               was_new,
    output logic [VAL_W-1:0]   read_value
);

    localparam int AW = $clog2(SLOTS);
    localparam int CW = (AW + 2 > 9) ? AW + 2 : 9;
    localparam bit POW2 = (SLOTS & (SLOTS - 1)) == 0;
    localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);
    localparam logic [HASH_W-1:0] SLOTS_H = HASH_W'(SLOTS);
    localparam logic [HASH_W-1:0] RECIP = HASH_W'((64'd1 << HASH_W) / SLOTS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_ADDR,
        S_PROBE,
        S_DONE
    } state_t;

    state_t             state_reg;
    logic [LIMIT_W-1:0] fill_limit_reg;
    logic [AW:0]        used_count_reg;
    logic [1:0]         kind_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [HASH_W-1:0]  hash_reg;
    logic [VAL_W-1:0]   value_reg;
    logic [AW-1:0]      at_reg;
    logic [AW-1:0]      tomb_at_reg;
    logic [AW-1:0]      n_reg;
    logic [1:0]         mod_step_reg;
    logic [HASH_W-1:0]  quot_reg;
    logic [HASH_W-1:0]  rem_reg;
    logic               hit_reg;
    logic               empty_reg;
    logic               tomb_reg;
    logic [VAL_W-1:0]   hit_value_reg;
    logic               resp_valid_reg;
    logic [1:0]         status_reg;
    logic               was_new_reg;
    logic [VAL_W-1:0]   read_value_reg;

    logic [AW-1:0]       at_next;
    logic [2*HASH_W-1:0] recip_prod;
    logic [HASH_W-1:0]   quot_prod;
    logic [HASH_W-1:0]   rem_fix;
    logic [AW-1:0]       rd_addr;
    logic [1:0]          rd_mark;
    logic [KEY_W-1:0]    rd_key;
    logic [VAL_W-1:0]    rd_value;
    logic                store_busy;
    logic                slot_empty;
    logic                slot_tomb;
    logic                slot_hit;
    logic                finish;
    logic                room;
    oaht_wr_t            wr;
    logic [AW-1:0]       wr_addr;
    logic [1:0]          dec_status;
    logic                dec_new;
    logic [VAL_W-1:0]    dec_value;
    logic                dec_inc;

    assign at_next = (at_reg == LAST_SLOT) ? '0 : at_reg + 1'b1;
    assign recip_prod = {{HASH_W{1'b0}}, hash_reg} * {{HASH_W{1'b0}}, RECIP};
    assign quot_prod = quot_reg * SLOTS_H;
    assign rem_fix = (rem_reg >= SLOTS_H) ? rem_reg - SLOTS_H : rem_reg;
    assign rd_addr = (state_reg == S_PROBE) ? at_next : at_reg;

    assign slot_empty = rd_mark == MARK_EMPTY;
    assign slot_tomb = rd_mark == MARK_TOMB;
    assign slot_hit = (rd_mark == MARK_LIVE) && (rd_key == key_reg);

    assign req_ready = (state_reg == S_IDLE) && !store_busy;
    assign finish = (state_reg == S_DONE) && (!resp_valid_reg || resp_ready);
    assign room = (CW'(used_count_reg) + CW'(1)) <= CW'(fill_limit_reg);

    always_comb
    begin
        wr = '0;
        wr.mark = MARK_LIVE;
        wr_addr = at_reg;
        dec_status = ST_MISSING;
        dec_new = 1'b0;
        dec_value = '0;
        dec_inc = 1'b0;
        case (kind_reg)
            KIND_GET:
            begin
                if (hit_reg)
                begin
                    dec_status = ST_OK;
                    dec_value = hit_value_reg;
                end
            end
            KIND_DEL:
            begin
                if (hit_reg)
                begin
                    dec_status = ST_OK;
                    wr.mark_we = 1'b1;
                    wr.mark = MARK_TOMB;
                end
            end
            KIND_SET:
            begin
                if (hit_reg)
                begin
                    dec_status = ST_OK;
                    wr.kv_we = 1'b1;
                end
                else if (tomb_reg)
                begin
                    dec_status = ST_OK;
                    dec_new = 1'b1;
                    wr.mark_we = 1'b1;
                    wr.kv_we = 1'b1;
                    wr_addr = tomb_at_reg;
                end
                else if (empty_reg && room)
                begin
                    dec_status = ST_OK;
                    dec_new = 1'b1;
                    dec_inc = 1'b1;
                    wr.mark_we = 1'b1;
                    wr.kv_we = 1'b1;
                end
                else
                begin
                    dec_status = ST_FULL;
                end
            end
            default:
            begin
                dec_status = ST_MISSING;
            end
        endcase
        if (!finish)
        begin
            wr.mark_we = 1'b0;
            wr.kv_we = 1'b0;
        end
    end

    oaht_store #(
        .SLOTS(SLOTS),
        .AW(AW)
    ) u_store (
        .clk(clk),
        .rst_n(rst_n),
        .rd_addr(rd_addr),
        .wr(wr),
        .wr_addr(wr_addr),
        .wr_key(key_reg),
        .wr_value(value_reg),
        .rd_mark(rd_mark),
        .rd_key(rd_key),
        .rd_value(rd_value),
        .busy(store_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_limit_reg <= LIMIT_RESET;
            used_count_reg <= '0;
            kind_reg <= KIND_GET;
            key_reg <= '0;
            hash_reg <= '0;
            value_reg <= '0;
            at_reg <= '0;
            tomb_at_reg <= '0;
            n_reg <= '0;
            mod_step_reg <= '0;
            quot_reg <= '0;
            rem_reg <= '0;
            hit_reg <= 1'b0;
            empty_reg <= 1'b0;
            tomb_reg <= 1'b0;
            hit_value_reg <= '0;
            resp_valid_reg <= 1'b0;
            status_reg <= ST_OK;
            was_new_reg <= 1'b0;
            read_value_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                fill_limit_reg <= cfg_wdata;
            end
            if (resp_ready)
            begin
                resp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req_valid && req_ready)
                    begin
                        kind_reg <= kind;
                        key_reg <= key_id;
                        hash_reg <= key_hash;
                        value_reg <= new_value;
                        at_reg <= POW2 ? key_hash[AW-1:0] : '0;
                        mod_step_reg <= '0;
                        n_reg <= '0;
                        hit_reg <= 1'b0;
                        empty_reg <= 1'b0;
                        tomb_reg <= 1'b0;
                        if (!(kind inside {KIND_GET, KIND_SET, KIND_DEL}) ||
                            ((kind inside {KIND_GET, KIND_DEL}) && used_count_reg == '0))
                        begin
                            state_reg <= S_DONE;
                        end
                        else if (POW2)
                        begin
                            state_reg <= S_ADDR;
                        end
                        else
                        begin
                            state_reg <= S_MOD;
                        end
                    end
                end
                S_MOD:
                begin
                    if (mod_step_reg == 2'd0)
                    begin
                        quot_reg <= recip_prod[2*HASH_W-1:HASH_W];
                    end
                    else if (mod_step_reg == 2'd1)
                    begin
                        rem_reg <= hash_reg - quot_prod;
                    end
                    else
                    begin
                        at_reg <= rem_fix[AW-1:0];
                        state_reg <= S_ADDR;
                    end
                    mod_step_reg <= mod_step_reg + 1'b1;
                end
                S_ADDR:
                begin
                    state_reg <= S_PROBE;
                end
                S_PROBE:
                begin
                    if (slot_empty)
                    begin
                        empty_reg <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else if (slot_hit)
                    begin
                        hit_reg <= 1'b1;
                        hit_value_reg <= rd_value;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        if (slot_tomb && !tomb_reg)
                        begin
                            tomb_reg <= 1'b1;
                            tomb_at_reg <= at_reg;
                        end
                        if (n_reg == LAST_SLOT)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            at_reg <= at_next;
                            n_reg <= n_reg + 1'b1;
                        end
                    end
                end
                S_DONE:
                begin
                    if (finish)
                    begin
                        resp_valid_reg <= 1'b1;
                        status_reg <= dec_status;
                        was_new_reg <= dec_new;
                        read_value_reg <= dec_value;
                        if (dec_inc)
                        begin
                            used_count_reg <= used_count_reg + 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign resp_valid = resp_valid_reg;
    assign status = status_reg;
    assign was_new = was_new_reg;
    assign read_value = read_value_reg;

    a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(used_count_reg) |-> (used_count_reg == $past(used_count_reg) + 1'b1))
        else $error("used count moved by other than one");

    a_new_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (resp_valid_reg && was_new_reg) |-> (status_reg == ST_OK))
        else $error("new insertion reported without success");

    a_resp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(resp_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the completion state");

    a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        store_busy |-> !req_ready)
        else $error("request taken during the clearing pass");

endmodule

// ----- rtl/oaht_store.sv -----
// Slot storage: mark memory with a clearing pass after reset, and key/value memory.
module oaht_store
    import oaht_pkg::*;
#(
    parameter int SLOTS = 256,
    parameter int AW = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [AW-1:0]    rd_addr,
    input  oaht_wr_t         wr,
    input  logic [AW-1:0]    wr_addr,
    input  logic [KEY_W-1:0] wr_key,
    input  logic [VAL_W-1:0] wr_value,
    output logic [1:0]       rd_mark,
    output logic [KEY_W-1:0] rd_key,
    output logic [VAL_W-1:0] rd_value,
    output logic             busy
);

    logic [1:0]             mark_mem [SLOTS];
    logic [KEY_W+VAL_W-1:0] kv_mem [SLOTS];
    logic [KEY_W+VAL_W-1:0] kv_rd;
    logic                   clr_busy_reg;
    logic [AW-1:0]          clr_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_idx_reg == AW'(SLOTS - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
            clr_idx_reg <= clr_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mark_mem[clr_idx_reg] <= MARK_EMPTY;
        end
        else if (wr.mark_we)
        begin
            mark_mem[wr_addr] <= wr.mark;
        end
        rd_mark <= mark_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr.kv_we)
        begin
            kv_mem[wr_addr] <= {wr_key, wr_value};
        end
        kv_rd <= kv_mem[rd_addr];
    end

    assign rd_key = kv_rd[KEY_W+VAL_W-1:VAL_W];
    assign rd_value = kv_rd[VAL_W-1:0];
    assign busy = clr_busy_reg;

endmodule
